### rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin tick scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int MAX_PROCS   = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_W      = 16;

  localparam int PIDX_W = 4;   // index field width on the ports
  localparam int FTIME_W = 16; // time field width on the ports
  localparam int SVC_W  = 16;  // remaining service width

  localparam int IDX_W  = $clog2(MAX_PROCS);
  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [IDX_W:0]  PROC_END   = (IDX_W + 1)'(MAX_PROCS);
  localparam logic [CNT_W-1:0] QUEUE_FULL = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_WAIT  = 2'd0,
    ST_READY = 2'd1,
    ST_RUN   = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [TIME_W-1:0]  arrival;
    logic [SVC_W-1:0]   remaining;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_CHK,
    S_SCAN,
    S_REQ,
    S_POP,
    S_DISP_RD,
    S_DISP_WR,
    S_OUT
  } seq_state_t;

  // Advance a queue pointer with wrap.
  function automatic logic [QIDX_W-1:0] q_next(input logic [QIDX_W-1:0] p);
    return (p == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

### rtl/rrts_ram.sv
// ----------------------------------------------------------------------------
// rrts_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/round_robin_tick_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_tick_scheduler
// Round-robin process scheduler with a quantum of one tick.
// ----------------------------------------------------------------------------
// A load item (mode 0) writes one process entry, unless the load is
// dropped, and returns a result with both valid flags low, going from
// the load check straight to the output state. A tick item (mode 1) walks
// all MAX_PROCS entries of the entry RAM one per cycle, queuing arrivals
// and charging the running entry, then requeues, pops and dispatches; when
// the queue is empty the dispatch read and write are skipped, and when a
// full queue keeps the preempted entry running the pop is skipped as well.
// The walk is set by the single read port of the entry RAM.
// The sequencer returns to idle between items. Each item yields exactly one
// result item; a new item is accepted as soon as the sequencer is back in
// idle, even while the last result is held in the output register waiting
// for out_ready. Process entries live in one RAM (status, arrival,
// remaining) and the ready queue in a second RAM; per-entry loaded flags
// are flops cleared by reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module round_robin_tick_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [rrts_pkg::PIDX_W-1:0] proc_index,
  input  logic [rrts_pkg::FTIME_W-1:0] arrival_tick,
  input  logic [rrts_pkg::SVC_W-1:0]  service_ticks,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        dispatch_valid,
  output logic [rrts_pkg::PIDX_W-1:0] dispatch_index,
  output logic                        finish_valid,
  output logic [rrts_pkg::PIDX_W-1:0] finish_index,
  output logic [rrts_pkg::FTIME_W-1:0] tick_now
);

  import rrts_pkg::*;

  // Sequencer
  seq_state_t state, state_next;

  // Latched command
  logic                 cmd_mode;
  logic [PIDX_W-1:0]    cmd_idx;
  logic [TIME_W-1:0]    cmd_arr;
  logic [SVC_W-1:0]     cmd_svc;
  logic [TIME_W-1:0]    now;

  // Scan pipeline: read address and the entry whose data is on the RAM output
  logic [IDX_W:0]       rd_idx;
  logic                 p_vld;
  logic [IDX_W-1:0]     p_idx;

  // Tick bookkeeping
  logic                 requeue;
  logic [IDX_W-1:0]     pre_idx;
  logic [TIME_W-1:0]    pre_arr;
  logic [SVC_W-1:0]     pre_rem;
  logic                 fin_v;
  logic [IDX_W-1:0]     fin_i;
  logic                 disp_v;
  logic [IDX_W-1:0]     disp_i;

  // Ready queue pointers and global state
  logic [QIDX_W-1:0]    head, tail;
  logic [CNT_W-1:0]     count;
  logic [MAX_PROCS-1:0] loaded;
  logic [TIME_W-1:0]    tick;

  // Entry RAM
  logic                 e_we;
  logic [IDX_W-1:0]     e_waddr, e_raddr;
  entry_t               e_wdata, e_rdata;

  // Queue RAM
  logic                 f_we;
  logic [IDX_W-1:0]     f_wdata, f_rdata;

  // Decoded conditions
  logic                 load_ok;
  logic                 scan_arrive;
  logic                 scan_run;
  logic                 q_has_room;
  logic                 out_go;
  logic [IDX_W-1:0]     cmd_addr;

  rrts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_PROCS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  rrts_ram #(
    .WIDTH (IDX_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (tail),
    .wdata (f_wdata),
    .raddr (head),
    .rdata (f_rdata)
  );

  assign in_ready   = (state == S_IDLE);
  assign q_has_room = (count < QUEUE_FULL);
  assign out_go     = !out_valid || out_ready;
  assign cmd_addr   = IDX_W'(cmd_idx);

  // A load is dropped when out of range or aimed at a queued or running entry.
  assign load_ok = (32'(cmd_idx) < MAX_PROCS) &&
                   !(loaded[cmd_addr] &&
                     (e_rdata.status == ST_READY || e_rdata.status == ST_RUN));

  // Arrivals that find the queue full stay waiting for a later tick.
  assign scan_arrive = p_vld && loaded[p_idx] && (e_rdata.status == ST_WAIT) &&
                       (e_rdata.arrival <= now) && q_has_room;
  assign scan_run    = p_vld && loaded[p_idx] && (e_rdata.status == ST_RUN);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = mode ? S_SCAN : S_LD_CHK;
        end
      end
      S_LD_CHK:  state_next = S_OUT;
      S_SCAN: begin
        if (rd_idx == PROC_END && !p_vld) begin
          state_next = S_REQ;
        end
      end
      S_REQ:     state_next = (requeue && !q_has_room) ? S_OUT : S_POP;
      S_POP:     state_next = (count != '0) ? S_DISP_RD : S_OUT;
      S_DISP_RD: state_next = S_DISP_WR;
      S_DISP_WR: state_next = S_OUT;
      S_OUT: begin
        if (out_go) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    e_we    = 1'b0;
    e_waddr = p_idx;
    e_wdata = e_rdata;
    e_raddr = rd_idx[IDX_W-1:0];
    f_we    = 1'b0;
    f_wdata = p_idx;
    case (state)
      S_IDLE: begin
        e_raddr = IDX_W'(proc_index);
      end
      S_LD_CHK: begin
        if (load_ok) begin
          e_we              = 1'b1;
          e_waddr           = cmd_addr;
          e_wdata.status    = ST_WAIT;
          e_wdata.arrival   = cmd_arr;
          e_wdata.remaining = (cmd_svc == '0) ? SVC_W'(1) : cmd_svc;
        end
      end
      S_SCAN: begin
        if (scan_arrive) begin
          e_we           = 1'b1;
          e_wdata.status = ST_READY;
          f_we           = 1'b1;
        end else if (scan_run) begin
          e_we = 1'b1;
          if (e_rdata.remaining <= SVC_W'(1)) begin
            e_wdata.status    = ST_DONE;
            e_wdata.remaining = '0;
          end else begin
            e_wdata.status    = ST_READY;
            e_wdata.remaining = e_rdata.remaining - 1'b1;
          end
        end
      end
      S_REQ: begin
        if (requeue) begin
          if (q_has_room) begin
            f_we    = 1'b1;
            f_wdata = pre_idx;
          end else begin
            // Queue full: the preempted entry keeps the processor.
            e_we              = 1'b1;
            e_waddr           = pre_idx;
            e_wdata.status    = ST_RUN;
            e_wdata.arrival   = pre_arr;
            e_wdata.remaining = pre_rem;
          end
        end
      end
      S_DISP_RD: begin
        e_raddr = f_rdata;
      end
      S_DISP_WR: begin
        e_we           = 1'b1;
        e_waddr        = disp_i;
        e_wdata.status = ST_RUN;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded    <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      tick      <= '0;
      out_valid <= 1'b0;
      p_vld     <= 1'b0;
    end else begin
      // Load a new result, or drop the held one once it is taken.
      if (state == S_OUT && out_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          p_vld <= 1'b0;
        end
        S_LD_CHK: begin
          if (load_ok) begin
            loaded[cmd_addr] <= 1'b1;
          end
        end
        S_SCAN: begin
          p_vld <= (rd_idx != PROC_END);
          if (scan_arrive) begin
            tail  <= q_next(tail);
            count <= count + 1'b1;
          end
        end
        S_REQ: begin
          if (requeue && q_has_room) begin
            tail  <= q_next(tail);
            count <= count + 1'b1;
          end
        end
        S_POP: begin
          if (count != '0) begin
            head  <= q_next(head);
            count <= count - 1'b1;
          end
        end
        S_OUT: begin
          if (out_go) begin
            // Advance the tick counter, holding at its maximum.
            if (cmd_mode && tick != '1) begin
              tick <= tick + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_mode <= mode;
          cmd_idx  <= proc_index;
          cmd_arr  <= TIME_W'(arrival_tick);
          cmd_svc  <= service_ticks;
          now      <= tick;
          rd_idx   <= '0;
          requeue  <= 1'b0;
          fin_v    <= 1'b0;
          fin_i    <= '0;
          disp_v   <= 1'b0;
          disp_i   <= '0;
        end
      end
      S_SCAN: begin
        if (rd_idx != PROC_END) begin
          rd_idx <= rd_idx + 1'b1;
          p_idx  <= rd_idx[IDX_W-1:0];
        end
        if (scan_run) begin
          if (e_rdata.remaining <= SVC_W'(1)) begin
            fin_v <= 1'b1;
            fin_i <= p_idx;
          end else begin
            requeue <= 1'b1;
            pre_idx <= p_idx;
            pre_arr <= e_rdata.arrival;
            pre_rem <= e_rdata.remaining - 1'b1;
          end
        end
      end
      S_REQ: begin
        if (requeue && !q_has_room) begin
          disp_v <= 1'b1;
          disp_i <= pre_idx;
        end
      end
      S_DISP_RD: begin
        disp_v <= 1'b1;
        disp_i <= f_rdata;
      end
      S_OUT: begin
        if (out_go) begin
          dispatch_valid <= disp_v;
          dispatch_index <= disp_v ? PIDX_W'(disp_i) : '0;
          finish_valid   <= fin_v;
          finish_index   <= fin_v ? PIDX_W'(fin_i) : '0;
          tick_now       <= FTIME_W'(now);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
